// ===== hdl/sqllex_pkg.sv =====
// Package for the SQL subset lexer: request/response structs, token codes,
// keyword table helpers. No dependencies.
package sqllex_pkg;

   localparam int KW_COUNT  = 20;
   localparam int KW_MAXLEN = 10;

   localparam logic [2:0] CLASS_KEYWORD = 3'd0;
   localparam logic [2:0] CLASS_IDENT   = 3'd1;
   localparam logic [2:0] CLASS_NUMBER  = 3'd2;
   localparam logic [2:0] CLASS_OPER    = 3'd3;
   localparam logic [2:0] CLASS_SEP     = 3'd4;
   localparam logic [2:0] CLASS_BAD     = 3'd5;

   localparam logic [6:0] CODE_NONE   = 7'd0;
   localparam logic [6:0] CODE_EQ     = 7'd1;
   localparam logic [6:0] CODE_LPAREN = 7'd1;
   localparam logic [6:0] CODE_RPAREN = 7'd2;
   localparam logic [6:0] CODE_IDENT  = 7'd100;
   localparam logic [6:0] CODE_NUMBER = 7'd101;

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_WORD    = 2'd1;
   localparam logic [1:0] MODE_NUM     = 2'd2;
   localparam logic [1:0] MODE_NUM_DOT = 2'd3;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_class;
      logic [6:0]  token_code;
      logic [15:0] token_start;
      logic [7:0]  token_length;
      logic        length_saturated;
      logic [7:0]  bad_byte;
      logic        run_last;
   } rsp_type;

   // keyword text, lowercase, zero padded
   function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned p);
      logic [8*KW_MAXLEN-1:0] s;
      begin
         case (k)
            0: s = {"create", 32'h0};
            1: s = {"drop", 48'h0};
            2: s = {"open", 48'h0};
            3: s = {"close", 40'h0};
            4: s = {"database", 16'h0};
            5: s = {"and", 56'h0};
            6: s = {"or", 64'h0};
            7: s = {"all", 56'h0};
            8: s = {"table", 40'h0};
            9: s = {"from", 48'h0};
            10: s = {"select", 32'h0};
            11: s = {"where", 40'h0};
            12: s = {"insert", 32'h0};
            13: s = {"into", 48'h0};
            14: s = {"values", 32'h0};
            15: s = {"update", 32'h0};
            16: s = {"delete", 32'h0};
            17: s = "primarykey";
            18: s = {"int", 56'h0};
            19: s = {"char", 48'h0};
            default: s = '0;
         endcase
         kw_char = s[8*(KW_MAXLEN-1-p) +: 8];
      end
   endfunction

   function automatic logic [3:0] kw_len(input int unsigned k);
      begin
         case (k)
            0, 10, 12, 14, 15, 16: kw_len = 4'd6;
            1, 2, 9, 13, 19: kw_len = 4'd4;
            3, 8, 11: kw_len = 4'd5;
            4: kw_len = 4'd8;
            5, 7, 18: kw_len = 4'd3;
            6: kw_len = 4'd2;
            17: kw_len = 4'd10;
            default: kw_len = 4'd0;
         endcase
      end
   endfunction

   typedef struct packed {
      logic [1:0]  count;
      rsp_type     r0;
      rsp_type     r1;
      rsp_type     r2;
   } batch_type;

endpackage

// ===== hdl/sqllex_front.sv =====
// Front end: accepts bytes, tracks lexer state, and produces a batch of up
// to three tokens per byte. Uses sqllex_pkg.
module sqllex_front #(
   parameter int MAX_LEXEME_LEN = 255,
   parameter int POSITION_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sqllex_pkg::req_type   req,
   output sqllex_pkg::batch_type batch
);
   localparam int LEN_BITS = $clog2(MAX_LEXEME_LEN + 2);
   localparam logic [LEN_BITS-1:0] LEN_CAP = LEN_BITS'(MAX_LEXEME_LEN + 1);

   logic [1:0]               mode_ff, mode_in;
   logic [19:0]              cand_ff, cand_in;
   logic [LEN_BITS-1:0]      len_ff, len_in;
   logic [POSITION_BITS-1:0] start_ff, start_in, pos_ff, pos_in;

   function automatic logic [LEN_BITS-1:0] grow(input logic [LEN_BITS-1:0] l,
                                                input logic [1:0] k);
      logic [LEN_BITS:0] v;
      begin
         v = {1'b0, l} + (LEN_BITS+1)'(k);
         grow = (v > {1'b0, LEN_CAP}) ? LEN_CAP : v[LEN_BITS-1:0];
      end
   endfunction

   function automatic sqllex_pkg::rsp_type mk(input logic [2:0] cls, input logic [6:0] code,
                                              input logic [POSITION_BITS-1:0] st,
                                              input logic [LEN_BITS-1:0] l,
                                              input logic [7:0] bad);
      sqllex_pkg::rsp_type r;
      begin
         r.token_class = cls;
         r.token_code = code;
         r.token_start = 16'(st);
         r.token_length = (l > LEN_BITS'(MAX_LEXEME_LEN)) ? 8'(MAX_LEXEME_LEN) : 8'(l);
         r.length_saturated = (l > LEN_BITS'(MAX_LEXEME_LEN));
         r.bad_byte = bad;
         r.run_last = 1'b0;
         mk = r;
      end
   endfunction

   always_comb begin
      logic [7:0] c, lc;
      logic alpha, digit, word_ch, done;
      logic [2:0] wcls;
      logic [6:0] wcode;
      sqllex_pkg::rsp_type q [3];
      logic [1:0] n;
      logic [1:0] m;
      logic [19:0] cd;
      logic [LEN_BITS-1:0] l;
      logic [POSITION_BITS-1:0] st, pm1;
      c = req.char_in;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      digit = (c >= "0" && c <= "9");
      word_ch = alpha || digit || c == "_";
      m = mode_ff; cd = cand_ff; l = len_ff; st = start_ff;
      pm1 = pos_ff - 1'b1;
      n = 2'd0; done = 1'b0;
      q[0] = '0; q[1] = '0; q[2] = '0;
      // keyword result from current candidates
      wcls = sqllex_pkg::CLASS_IDENT; wcode = sqllex_pkg::CODE_IDENT;
      for (int i = 0; i < 20; i++) begin
         if (cd[i] && LEN_BITS'(sqllex_pkg::kw_len(i)) == l) begin
            wcls = sqllex_pkg::CLASS_KEYWORD; wcode = 7'(i + 1);
         end
      end
      if (m == sqllex_pkg::MODE_NUM_DOT) begin
         if (digit) begin
            l = grow(l, 2'd2); m = sqllex_pkg::MODE_NUM; done = 1'b1;
         end else begin
            q[n] = mk(sqllex_pkg::CLASS_NUMBER, sqllex_pkg::CODE_NUMBER, st, l, 8'd0);
            n = n + 1'b1;
            q[n] = mk(sqllex_pkg::CLASS_BAD, sqllex_pkg::CODE_NONE, pm1, LEN_BITS'(1), ".");
            n = n + 1'b1;
            m = sqllex_pkg::MODE_IDLE;
         end
      end
      if (!done && m == sqllex_pkg::MODE_WORD) begin
         if (word_ch) begin
            for (int i = 0; i < 20; i++)
               if (l >= LEN_BITS'(sqllex_pkg::kw_len(i)) ||
                   sqllex_pkg::kw_char(i, 32'(l[3:0])) != lc)
                  cd[i] = 1'b0;
            l = grow(l, 2'd1); done = 1'b1;
         end
      end else if (!done && m == sqllex_pkg::MODE_NUM) begin
         if (digit) begin
            l = grow(l, 2'd1); done = 1'b1;
         end else if (c == ".") begin
            m = sqllex_pkg::MODE_NUM_DOT; done = 1'b1;
         end
      end
      if (!done && m != sqllex_pkg::MODE_IDLE) begin
         if (m == sqllex_pkg::MODE_WORD)
            q[n] = mk(wcls, wcode, st, l, 8'd0);
         else
            q[n] = mk(sqllex_pkg::CLASS_NUMBER, sqllex_pkg::CODE_NUMBER, st, l, 8'd0);
         n = n + 1'b1;
         m = sqllex_pkg::MODE_IDLE;
      end
      if (!done) begin
         if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
         end else if (alpha || c == "_") begin
            m = sqllex_pkg::MODE_WORD; st = pos_ff; l = '0;
            for (int i = 0; i < 20; i++)
               cd[i] = (sqllex_pkg::kw_char(i, 0) == lc);
            l = LEN_BITS'(1);
         end else if (digit) begin
            m = sqllex_pkg::MODE_NUM; st = pos_ff; l = LEN_BITS'(1);
         end else if (c == "=") begin
            q[n] = mk(sqllex_pkg::CLASS_OPER, sqllex_pkg::CODE_EQ, pos_ff, LEN_BITS'(1), 8'd0);
            n = n + 1'b1;
         end else if (c == "(") begin
            q[n] = mk(sqllex_pkg::CLASS_SEP, sqllex_pkg::CODE_LPAREN, pos_ff, LEN_BITS'(1),
                      8'd0);
            n = n + 1'b1;
         end else if (c == ")") begin
            q[n] = mk(sqllex_pkg::CLASS_SEP, sqllex_pkg::CODE_RPAREN, pos_ff, LEN_BITS'(1),
                      8'd0);
            n = n + 1'b1;
         end else begin
            q[n] = mk(sqllex_pkg::CLASS_BAD, sqllex_pkg::CODE_NONE, pos_ff, LEN_BITS'(1), c);
            n = n + 1'b1;
         end
      end
      pos_in = pos_ff + 1'b1;
      if (req.end_of_text) begin
         // flush: word keyword check uses updated candidates
         wcls = sqllex_pkg::CLASS_IDENT; wcode = sqllex_pkg::CODE_IDENT;
         for (int i = 0; i < 20; i++)
            if (cd[i] && LEN_BITS'(sqllex_pkg::kw_len(i)) == l) begin
               wcls = sqllex_pkg::CLASS_KEYWORD; wcode = 7'(i + 1);
            end
         if (m == sqllex_pkg::MODE_WORD) begin
            q[n] = mk(wcls, wcode, st, l, 8'd0); n = n + 1'b1;
         end else if (m != sqllex_pkg::MODE_IDLE) begin
            q[n] = mk(sqllex_pkg::CLASS_NUMBER, sqllex_pkg::CODE_NUMBER, st, l, 8'd0);
            n = n + 1'b1;
            if (m == sqllex_pkg::MODE_NUM_DOT) begin
               q[n] = mk(sqllex_pkg::CLASS_BAD, sqllex_pkg::CODE_NONE, pos_ff, LEN_BITS'(1),
                         ".");
               n = n + 1'b1;
            end
         end
         m = sqllex_pkg::MODE_IDLE;
         pos_in = '0;
      end
      if (n != 2'd0) q[n - 1'b1].run_last = 1'b1;
      mode_in = m; cand_in = cd; len_in = l; start_in = st;
      batch.count = n; batch.r0 = q[0]; batch.r1 = q[1]; batch.r2 = q[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sqllex_pkg::MODE_IDLE;
         cand_ff <= '1;
         len_ff <= '0;
         start_ff <= '0;
         pos_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         cand_ff <= cand_in;
         len_ff <= len_in;
         start_ff <= start_in;
         pos_ff <= pos_in;
      end
   end
endmodule

// ===== hdl/sqllex_back.sv =====
// Back end: batch queue between front and output, and the serializer that
// delivers one token per cycle while rsp_stall is low. Uses sqllex_pkg.
module sqllex_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sqllex_pkg::batch_type batch,
   output logic                  has_room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sqllex_pkg::rsp_type   rsp_data
);
   sqllex_pkg::batch_type q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] sub_ff, sub_in;
   logic       pop, take;
   sqllex_pkg::batch_type head;

   assign head = q_ff[rp_ff];
   assign has_room = (cnt_ff != 2'd2) || pop;
   assign rsp_valid = (cnt_ff != 2'd0);
   always_comb begin
      case (sub_ff)
         2'd0: rsp_data = head.r0;
         2'd1: rsp_data = head.r1;
         default: rsp_data = head.r2;
      endcase
   end
   assign take = rsp_valid && !rsp_stall;
   assign pop = take && (sub_ff + 1'b1 == head.count);
   assign sub_in = pop ? 2'd0 : (take ? sub_ff + 1'b1 : sub_ff);
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= batch;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0; sub_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
      end
   end
endmodule

// ===== hdl/sql_subset_lexer_unit.sv =====
// Top level of the SQL subset lexer: front classifier plus token queue.
// Depends on sqllex_pkg, sqllex_front, sqllex_back.
//
// Usage: present one text byte per request on req_valid/req_data; the byte
// with end_of_text set closes the text, flushes any open word or number and
// restarts positions at zero. Each byte yields zero to three tokens on the
// rsp channel, one per cycle while rsp_stall is low, the last of a byte
// marked by run_last. Throughput: one byte per cycle while each byte gives
// at most one token and rsp_stall is low; a byte that gives more than one
// token holds the output until all are sent. The two-entry token-batch
// queue sets this: the front stalls only when it is full. Reset clears the
// lexer state and empties the queue. When the receiver stalls, the current
// token holds and the queue fills, then req_stall rises. Bytes that give no
// token are not queued.
module sql_subset_lexer_unit #(
   parameter int MAX_LEXEME_LEN = 255,
   parameter int POSITION_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sqllex_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sqllex_pkg::rsp_type rsp_data
);
   sqllex_pkg::batch_type batch;
   logic has_room, accept;

   assign req_stall = !has_room;
   assign accept = req_valid && has_room;

   sqllex_front #(.MAX_LEXEME_LEN(MAX_LEXEME_LEN), .POSITION_BITS(POSITION_BITS)) u_front (
      .clock(clock), .reset(reset), .step(accept), .req(req_data), .batch(batch));

   sqllex_back u_back (
      .clock(clock), .reset(reset), .push(accept && batch.count != 2'd0), .batch(batch),
      .has_room(has_room), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data));

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      u_back.cnt_ff == 2'd2 && !(rsp_valid && !rsp_stall) |-> req_stall)
      else $error("queue overflow possible");
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.token_class <= sqllex_pkg::CLASS_BAD)
      else $error("bad token class");
   a_bad_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_class != sqllex_pkg::CLASS_BAD |-> rsp_data.bad_byte == 8'd0)
      else $error("bad_byte set on good token");
endmodule
